### rtl/cat_pkg.sv
`default_nettype none

package cat_pkg;

    // table geometry
    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int HALF_W  = 16;
    localparam int KEY_W   = 2 * HALF_W;
    localparam int LED_W   = 8;

    // event kinds
    typedef enum logic {
        CMD_CONNECT = 1'b0,
        CMD_CLOSE   = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_REMOVED = 3'd3,
        ST_ABSENT  = 3'd4,
        ST_ZERO    = 3'd5
    } t_status;

endpackage

`default_nettype wire

### rtl/client_address_table.sv
// client address table: packed table of connected client addresses
// pipeline: input register, then result register; a word waits in the input
// register while a stalled receiver holds a result; else one word per cycle;
// lookup, insert and compaction shift all finish in one pass between registers
// reset: synchronous, active low; clears the table to empty, the count to zero
// and both valid flags
`default_nettype none

module client_address_table (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_cmd,
    input  wire logic [cat_pkg::HALF_W-1:0] i_addr_first_half,
    input  wire logic [cat_pkg::HALF_W-1:0] i_addr_second_half,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [2:0]                      o_status,
    output logic [2:0]                      o_slot,
    output logic [3:0]                      o_client_count,
    output logic [cat_pkg::LED_W-1:0]       o_led_lit
);

    // table state
    logic [cat_pkg::KEY_W-1:0] r_entries [cat_pkg::ENTRIES];
    logic [cat_pkg::KEY_W-1:0] n_entries [cat_pkg::ENTRIES];
    logic [cat_pkg::CNT_W-1:0] r_count;
    logic [cat_pkg::CNT_W-1:0] n_count;

    // input stage
    logic                      r_s1_valid;
    logic                      r_s1_cmd;
    logic [cat_pkg::KEY_W-1:0] r_s1_key;

    // result stage
    logic                      r_out_valid;
    cat_pkg::t_status          r_out_status;
    logic [2:0]                r_out_slot;
    logic [3:0]                r_out_count;
    logic [cat_pkg::LED_W-1:0] r_out_led;

    // handshake
    logic out_free;
    logic s1_adv;
    logic in_accept;

    // lookup results
    logic                      hit_found;
    logic [cat_pkg::IDX_W-1:0] hit_idx;
    logic                      empty_found;
    logic [cat_pkg::IDX_W-1:0] empty_idx;
    cat_pkg::t_status          status;
    logic [cat_pkg::IDX_W-1:0] slot_idx;
    logic [cat_pkg::LED_W-1:0] led;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // first matching slot and first empty slot
    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = cat_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_entries[i] == r_s1_key) begin
                hit_found = 1'b1;
                hit_idx   = cat_pkg::IDX_W'(i);
            end
            if (r_entries[i] == '0) begin
                empty_found = 1'b1;
                empty_idx   = cat_pkg::IDX_W'(i);
            end
        end
    end

    // event decode and table update
    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        status    = cat_pkg::ST_ZERO;
        slot_idx  = '0;
        priority if (r_s1_key == '0) begin
            status = cat_pkg::ST_ZERO;
        end else if (r_s1_cmd == cat_pkg::CMD_CONNECT) begin
            priority if (hit_found) begin
                status   = cat_pkg::ST_PRESENT;
                slot_idx = hit_idx;
            end else if (!empty_found) begin
                status = cat_pkg::ST_FULL;
            end else begin
                n_entries[empty_idx] = r_s1_key;
                if (r_count < cat_pkg::CNT_W'(cat_pkg::ENTRIES)) begin
                    n_count = r_count + 1'b1;
                end
                status   = cat_pkg::ST_ADDED;
                slot_idx = empty_idx;
            end
        end else begin
            priority if (!hit_found) begin
                status = cat_pkg::ST_ABSENT;
            end else begin
                // close the gap: later entries move down one slot
                for (int i = 0; i < cat_pkg::ENTRIES - 1; i++) begin
                    if (cat_pkg::IDX_W'(i) >= hit_idx) begin
                        n_entries[i] = r_entries[i + 1];
                    end
                end
                n_entries[cat_pkg::ENTRIES - 1] = '0;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                status   = cat_pkg::ST_REMOVED;
                slot_idx = hit_idx;
            end
        end
    end

    // thermometer of the new count, eight lit at most
    always_comb begin
        for (int i = 0; i < cat_pkg::LED_W; i++) begin
            led[i] = (8'(n_count) > 8'(i));
        end
    end

    // control and table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            for (int i = 0; i < cat_pkg::ENTRIES; i++) begin
                r_entries[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_entries   <= n_entries;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_cmd;
            r_s1_key <= {i_addr_second_half, i_addr_first_half};
        end
        if (s1_adv) begin
            r_out_status <= status;
            r_out_slot   <= 3'(slot_idx);
            r_out_count  <= 4'(n_count);
            r_out_led    <= led;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_client_count = r_out_count;
    assign o_led_lit      = r_out_led;

    // count stays within the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cat_pkg::CNT_W'(cat_pkg::ENTRIES))
        else $error("client count beyond table size");

    // table stays packed: the slot at the count is empty
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < cat_pkg::CNT_W'(cat_pkg::ENTRIES))
        |-> (r_entries[r_count[cat_pkg::IDX_W-1:0]] == '0))
        else $error("table not packed");

    // an add raises the count by one
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && status == cat_pkg::ST_ADDED) |=> (r_count == $past(r_count) + 1'b1))
        else $error("add did not raise count");

    // a removal lowers the count by one
    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && status == cat_pkg::ST_REMOVED) |=> (r_count == $past(r_count) - 1'b1))
        else $error("removal did not lower count");

    // input stalls only while the input stage holds a word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held word");

endmodule

`default_nettype wire

### sim/address_table_checker.sv
`timescale 1ns / 1ps

module address_table_checker
    import cat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_cmd,
    input  logic [HALF_W-1:0] i_addr_first_half,
    input  logic [HALF_W-1:0] i_addr_second_half,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_status,
    input  logic [2:0]        i_slot,
    input  logic [3:0]        i_client_count,
    input  logic [LED_W-1:0]  i_led_lit,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_words_in,
    output int                o_words_out,
    output logic [5:0]        o_status_seen
);

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       slot;
        logic [3:0]       client_count;
        logic [LED_W-1:0] led_lit;
    } t_outcome;

    // shadow of the client table
    logic [KEY_W-1:0] client_keys [ENTRIES];
    int               live_count;
    t_outcome         pending_results [$];
    t_outcome         want;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            client_keys[i] = '0;
        end
        live_count    = 0;
        o_fail_count  = 0;
        o_pending     = 0;
        o_words_in    = 0;
        o_words_out   = 0;
        o_status_seen = '0;
    end

    function automatic int find_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (client_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // update the shadow table for one event and work out its result
    task automatic apply_client_event(input t_cmd kind, input logic [KEY_W-1:0] key,
                                      output t_outcome res);
        int      hit;
        t_status st;
        st = ST_ZERO;
        res = '0;
        if (key == '0) begin
            st = ST_ZERO;
        end else if (kind == CMD_CONNECT) begin
            hit = find_key(key);
            if (hit >= 0) begin
                st = ST_PRESENT;
                res.slot = hit[2:0];
            end else begin
                hit = find_key('0);
                if (hit < 0) begin
                    st = ST_FULL;
                end else begin
                    client_keys[hit] = key;
                    if (live_count < ENTRIES) live_count++;
                    st = ST_ADDED;
                    res.slot = hit[2:0];
                end
            end
        end else begin
            hit = find_key(key);
            if (hit < 0) begin
                st = ST_ABSENT;
            end else begin
                // close compacts the table toward slot zero
                for (int i = hit; i + 1 < ENTRIES; i++) begin
                    client_keys[i] = client_keys[i + 1];
                end
                client_keys[ENTRIES - 1] = '0;
                if (live_count > 0) live_count--;
                st = ST_REMOVED;
                res.slot = hit[2:0];
            end
        end
        res.status       = st;
        res.client_count = live_count[3:0];
        for (int i = 0; i < LED_W; i++) begin
            res.led_lit[i] = (live_count > i);
        end
    endtask

    task automatic report(input string what, input int exp_v, input int got_v);
        o_fail_count++;
        $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // result word first, then the input word of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_words_out++;
            if (pending_results.size() == 0) begin
                o_fail_count++;
                $display("%0t: result word with none expected, status %0d slot %0d",
                         $time, i_status, i_slot);
            end else begin
                want = pending_results.pop_front();
                o_pending--;
                if (i_status != want.status) report("status", want.status, i_status);
                if (i_slot != want.slot) report("slot", want.slot, i_slot);
                if (i_client_count != want.client_count)
                    report("client_count", want.client_count, i_client_count);
                if (i_led_lit != want.led_lit) report("led_lit", want.led_lit, i_led_lit);
                o_status_seen[want.status] = 1'b1;
            end
        end
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            apply_client_event(t_cmd'(i_cmd), {i_addr_second_half, i_addr_first_half}, want);
            pending_results.push_back(want);
            o_pending++;
            o_words_in++;
        end
    end

endmodule

### sim/tb_client_address_table.sv
`timescale 1ns / 1ps

module tb_client_address_table;
    import cat_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 200;
    localparam int POOL_SIZE  = 12;
    localparam int LONG_HOLD  = 90;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_cmd              cmd;
    logic [HALF_W-1:0] addr_first;
    logic [HALF_W-1:0] addr_second;
    logic              out_valid;
    logic              out_stall;
    logic [2:0]        status;
    logic [2:0]        slot;
    logic [3:0]        client_count;
    logic [LED_W-1:0]  led_lit;

    int                fail_count;
    int                pending;
    int                words_in;
    int                words_out;
    logic [5:0]        status_seen;

    bit                sender_burst;
    bit                long_hold_req;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    int                connect_pct [PHASES] = '{80, 50, 20, 90, 30, 60, 10, 70};

    client_address_table u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_addr_first_half  (addr_first),
        .i_addr_second_half (addr_second),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_slot             (slot),
        .o_client_count     (client_count),
        .o_led_lit          (led_lit)
    );

    address_table_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_addr_first_half  (addr_first),
        .i_addr_second_half (addr_second),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_status           (status),
        .i_slot             (slot),
        .i_client_count     (client_count),
        .i_led_lit          (led_lit),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_words_in         (words_in),
        .o_words_out        (words_out),
        .o_status_seen      (status_seen)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // offer one word after a random gap and hold it until accepted
    task automatic send_word(input t_cmd kind, input logic [HALF_W-1:0] first,
                             input logic [HALF_W-1:0] second);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= kind;
        addr_first  <= first;
        addr_second <= second;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [KEY_W-1:0] make_key();
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        case ($urandom_range(0, 7))
            0: begin
                lo = HALF_W'($urandom_range(1, 65535));
                hi = '0;
            end
            1: begin
                lo = '0;
                hi = HALF_W'($urandom_range(1, 65535));
            end
            default: begin
                lo = HALF_W'($urandom);
                hi = HALF_W'($urandom);
                if ({hi, lo} == '0) lo = 16'h0001;
            end
        endcase
        return {hi, lo};
    endfunction

    // receiver: random stall before each result word, with bursts and one long hold
    initial begin : receiver
        int  hold;
        bit  rx_burst;
        rx_burst = 1'b0;
        forever begin
            if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 13);
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
            else idle++;
        end
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [KEY_W-1:0] key;
        int               pick;
        t_cmd             kind;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_CONNECT;
        addr_first    = '0;
        addr_second   = '0;
        out_stall     = 1'b0;
        sender_burst  = 1'b0;
        long_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero address, absent close, fill to full, compaction
        send_word(CMD_CONNECT, 16'h0000, 16'h0000);
        send_word(CMD_CLOSE,   16'h0000, 16'h0000);
        send_word(CMD_CLOSE,   16'h0000, 16'hFFFF);
        send_word(CMD_CONNECT, 16'hFFFF, 16'hFFFF);
        send_word(CMD_CONNECT, 16'hFFFF, 16'hFFFF);
        send_word(CMD_CONNECT, 16'h0001, 16'h0000);
        send_word(CMD_CONNECT, 16'h0000, 16'h0001);
        send_word(CMD_CONNECT, 16'h8000, 16'h0000);
        send_word(CMD_CONNECT, 16'h0000, 16'h8000);
        send_word(CMD_CONNECT, 16'h00FF, 16'hFF00);
        send_word(CMD_CONNECT, 16'hFF00, 16'h00FF);
        send_word(CMD_CONNECT, 16'h1234, 16'h5678);
        send_word(CMD_CONNECT, 16'hAAAA, 16'h5555);
        send_word(CMD_CONNECT, 16'h0000, 16'h0000);
        send_word(CMD_CLOSE,   16'h0001, 16'h0000);
        send_word(CMD_CONNECT, 16'h1234, 16'h5678);
        send_word(CMD_CONNECT, 16'hAAAA, 16'h5555);
        send_word(CMD_CLOSE,   16'hFFFF, 16'hFFFF);
        send_word(CMD_CLOSE,   16'hAAAA, 16'h5555);
        send_word(CMD_CLOSE,   16'hFFFF, 16'hFFFF);
        send_word(CMD_CONNECT, 16'h5555, 16'hAAAA);

        // random phases over a small address pool, biased toward connect or close
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = make_key();
            sender_burst = (ph % 3 == 2);
            if (ph == 1) begin
                long_hold_req = 1'b1;
                sender_burst  = 1'b1;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) key = '0;
                else if (pick < 12) key = make_key();
                else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                kind = ($urandom_range(0, 99) < connect_pct[ph]) ? CMD_CONNECT : CMD_CLOSE;
                if (ph == 1 && n == 40) sender_burst = 1'b0;
                send_word(kind, key[HALF_W-1:0], key[KEY_W-1:HALF_W]);
            end
            // pause until every result of the phase has come back
            @(negedge clk);
            in_valid <= 1'b0;
            wait (pending == 0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);

        $display("run: %0d events sent, %0d results checked", words_in, words_out);
        $display("status kinds seen (bit per code): %b", status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
